@@ src/sequence_buffer_engine_defines.svh @@
// Assertion macros for the sequence buffer engine.
// Depends on nothing; the asserting module provides clk and rst_n in scope.
`ifndef SEQUENCE_BUFFER_ENGINE_DEFINES_SVH
`define SEQUENCE_BUFFER_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
// Invariant checked at every edge outside reset.
`define SBE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Same-cycle implication.
`define SBE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define SBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SBE_ASSERT_ALWAYS(lbl, cond, msg)
`define SBE_ASSERT_IMPL(lbl, ante, cons, msg)
`define SBE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ src/sbe_pkg.sv @@
// Shared types and constants of the sequence buffer engine.
// No dependencies.
package sbe_pkg;

  localparam int DATA_W = 32;
  localparam int REQ_W  = 3;
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 6;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD_FRONT  = 3'd0,
    REQ_ADD_BACK   = 3'd1,
    REQ_RMV_FRONT  = 3'd2,
    REQ_RMV_BACK   = 3'd3,
    REQ_RMV_VALUE  = 3'd4,
    REQ_READ_FIRST = 3'd5,
    REQ_READ_LAST  = 3'd6,
    REQ_CLEAR      = 3'd7
  } req_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ELEM = 2'd0,
    KIND_END  = 2'd1,
    KIND_ACK  = 2'd2
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_COUNT = 2'd3
  } status_t;

  // Pending response of a request: what goes out as its final beat.
  typedef struct packed {
    kind_t   kind;
    status_t status;
  } resp_t;

endpackage

@@ src/sbe_if.sv @@
// Valid/ready channel interfaces of the sequence buffer engine.
// Depends on sbe_pkg for field widths.
interface sbe_in_if;
  import sbe_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [DATA_W-1:0] operand;

  modport source (output valid, output req_type, output operand, input ready);
  modport sink   (input valid, input req_type, input operand, output ready);
endinterface

interface sbe_out_if;
  import sbe_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] value;
  logic [STAT_W-1:0]        status;
  logic [LEN_W-1:0]         length;
  logic                     last;

  modport source (output valid, output kind, output value, output status,
                  output length, output last, input ready);
  modport sink   (input valid, input kind, input value, input status,
                  input length, input last, output ready);
endinterface

@@ src/sequence_buffer_engine.sv @@
// Sequence buffer engine: double-ended queue of signed words with removal by value.
// Add/remove front or back and clear: done on the accept, then acked from S_RESP.
// Removal by value: a compacting walk, one entry walked per cycle; an empty store skips it.
// Read first/last N: min(N, length) element beats, then an end beat; one element
// beat per cycle while the sink is ready; sink stalls hold back every result beat.
// Sync active-low reset empties the queue, front at slot 0; store contents are kept.
`include "sequence_buffer_engine_defines.svh"

module sequence_buffer_engine #(
  parameter int CAPACITY = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  sbe_in_if.sink    in_ch,
  sbe_out_if.source out_ch
);
  import sbe_pkg::*;

  // Slot index width and fill count width (the count must hold CAPACITY itself).
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [IW-1:0] ONE_I  = IW'(1);
  localparam logic [IW-1:0] LAST_I = IW'(CAPACITY - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RMV  = 5'b00010,
    S_READ = 5'b00100,
    S_RESP = 5'b01000,
    S_HOLD = 5'b10000
  } state_t;

  // Sequencer state
  state_t state_r, state_nxt;
  logic [IW-1:0] front_r, front_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  resp_t         resp_r, resp_nxt;

  // Walk state of removal and read-out; the read slot is shared by both
  logic [IW-1:0] rd_slot_r, rd_slot_nxt;
  logic [IW-1:0] wr_slot_r, wr_slot_nxt;
  logic [CW-1:0] i_r, i_nxt;       // entries read so far in a removal walk
  logic [CW-1:0] k_r, k_nxt;       // entries kept so far
  logic [CW-1:0] rem_r, rem_nxt;   // reads still to issue in a read-out
  logic          p_r, p_nxt;       // read word arrives this cycle (removal)
  logic          dv_r, dv_nxt;     // read word held, waiting for output (read-out)
  logic signed [DATA_W-1:0] opnd_r, opnd_nxt;

  // Output register
  logic                     out_vld_r;
  kind_t                    kind_r;
  logic signed [DATA_W-1:0] value_r;
  status_t                  status_r;
  logic [LEN_W-1:0]         length_r;
  logic                     last_r;

  // Store and unit connections
  logic                     mem_we, mem_re;
  logic [IW-1:0]            mem_waddr, mem_raddr;
  logic signed [DATA_W-1:0] mem_wdata, mem_rdata;
  logic [IW-1:0]            alu_base, alu_off, alu_slot, alu_wr_next;
  logic                     alu_neq;

  // Request decode
  req_t          req;
  logic          in_fire;
  logic          count_pos;
  logic [CW-1:0] n_sel;
  logic [IW-1:0] start_off;
  logic          out_free, out_load, out_elem;

  assign req       = req_t'(in_ch.req_type);
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_free  = !out_vld_r || out_ch.ready;
  assign count_pos = !in_ch.operand[DATA_W-1] && (in_ch.operand != '0);

  // Clip the read count to the length; start offset of a read-last.
  always_comb begin
    if (DATA_W'(fill_r) > $unsigned(in_ch.operand)) begin
      n_sel = CW'(in_ch.operand);
    end else begin
      n_sel = fill_r;
    end
    if (req == REQ_READ_FIRST) begin
      start_off = '0;
    end else begin
      start_off = IW'(fill_r - n_sel);
    end
  end

  sbe_store #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  sbe_alu #(
    .CAPACITY (CAPACITY),
    .IW       (IW)
  ) u_alu (
    .base    (alu_base),
    .offset  (alu_off),
    .wr_slot (wr_slot_r),
    .cmp_a   (mem_rdata),
    .cmp_b   (opnd_r),
    .slot    (alu_slot),
    .wr_next (alu_wr_next),
    .neq     (alu_neq)
  );

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    front_nxt   = front_r;
    fill_nxt    = fill_r;
    resp_nxt    = resp_r;
    rd_slot_nxt = rd_slot_r;
    wr_slot_nxt = wr_slot_r;
    i_nxt       = i_r;
    k_nxt       = k_r;
    rem_nxt     = rem_r;
    p_nxt       = 1'b0;
    dv_nxt      = dv_r;
    opnd_nxt    = opnd_r;
    mem_we      = 1'b0;
    mem_waddr   = alu_slot;
    mem_wdata   = in_ch.operand;
    mem_re      = 1'b0;
    mem_raddr   = rd_slot_r;
    out_load    = 1'b0;
    out_elem    = 1'b0;
    alu_base    = rd_slot_r;
    alu_off     = ONE_I;

    unique case (state_r)
      S_IDLE: begin
        // The unit works on the front slot for every new request.
        alu_base = front_r;
        case (req) inside
          REQ_ADD_FRONT:                 alu_off = LAST_I;
          REQ_ADD_BACK:                  alu_off = IW'(fill_r);
          REQ_READ_FIRST, REQ_READ_LAST: alu_off = start_off;
          default:                       alu_off = ONE_I;
        endcase

        if (in_fire) begin
          resp_nxt  = '{kind: KIND_ACK, status: ST_OK};
          state_nxt = S_RESP;
          unique case (req) inside
            REQ_ADD_FRONT: begin
              if (fill_r >= CAP_C) begin
                resp_nxt.status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                front_nxt = alu_slot;
                fill_nxt  = fill_r + CW'(1);
              end
            end
            REQ_ADD_BACK: begin
              if (fill_r >= CAP_C) begin
                resp_nxt.status = ST_FULL;
              end else begin
                mem_we   = 1'b1;
                fill_nxt = fill_r + CW'(1);
              end
            end
            REQ_RMV_FRONT: begin
              if (fill_r == '0) begin
                resp_nxt.status = ST_EMPTY;
              end else begin
                front_nxt = alu_slot;
                fill_nxt  = fill_r - CW'(1);
              end
            end
            REQ_RMV_BACK: begin
              if (fill_r == '0) begin
                resp_nxt.status = ST_EMPTY;
              end else begin
                fill_nxt = fill_r - CW'(1);
              end
            end
            REQ_RMV_VALUE: begin
              if (fill_r == '0) begin
                resp_nxt.status = ST_EMPTY;
              end else begin
                // Start a compacting walk from the front.
                rd_slot_nxt = front_r;
                wr_slot_nxt = front_r;
                i_nxt       = '0;
                k_nxt       = '0;
                opnd_nxt    = in_ch.operand;
                state_nxt   = S_RMV;
              end
            end
            REQ_READ_FIRST, REQ_READ_LAST: begin
              resp_nxt.kind = KIND_END;
              if (!count_pos) begin
                resp_nxt.status = ST_COUNT;
              end else if (n_sel != '0) begin
                rd_slot_nxt = alu_slot;
                rem_nxt     = n_sel;
                dv_nxt      = 1'b0;
                state_nxt   = S_READ;
              end
            end
            REQ_CLEAR: begin
              front_nxt = '0;
              fill_nxt  = '0;
            end
          endcase
        end
      end

      S_RMV: begin
        // Issue one read per cycle; compare the word that arrives and
        // write it back at the keep pointer if it survives.
        if (i_r != fill_r) begin
          mem_re      = 1'b1;
          rd_slot_nxt = alu_slot;
          i_nxt       = i_r + CW'(1);
          p_nxt       = 1'b1;
        end
        if (p_r && alu_neq) begin
          mem_we      = 1'b1;
          mem_waddr   = wr_slot_r;
          mem_wdata   = mem_rdata;
          wr_slot_nxt = alu_wr_next;
          k_nxt       = k_r + CW'(1);
        end
        if ((i_r == fill_r) && !p_r) begin
          fill_nxt  = k_r;
          state_nxt = S_RESP;
        end
      end

      S_READ: begin
        if (!dv_r) begin
          mem_re      = 1'b1;
          rd_slot_nxt = alu_slot;
          rem_nxt     = rem_r - CW'(1);
          dv_nxt      = 1'b1;
        end else if (out_free) begin
          // Hand the held word to the output and fetch the next one.
          out_load = 1'b1;
          out_elem = 1'b1;
          if (rem_r != '0) begin
            mem_re      = 1'b1;
            rd_slot_nxt = alu_slot;
            rem_nxt     = rem_r - CW'(1);
          end else begin
            dv_nxt    = 1'b0;
            state_nxt = S_RESP;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      front_r <= '0;
      fill_r  <= '0;
      p_r     <= 1'b0;
      dv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      fill_r  <= fill_nxt;
      p_r     <= p_nxt;
      dv_r    <= dv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    resp_r    <= resp_nxt;
    rd_slot_r <= rd_slot_nxt;
    wr_slot_r <= wr_slot_nxt;
    i_r       <= i_nxt;
    k_r       <= k_nxt;
    rem_r     <= rem_nxt;
    opnd_r    <= opnd_nxt;
  end

  // Output register: load a beat when free, drop valid once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      length_r <= LEN_W'(fill_r);
      if (out_elem) begin
        kind_r   <= KIND_ELEM;
        value_r  <= mem_rdata;
        status_r <= ST_OK;
        last_r   <= 1'b0;
      end else begin
        kind_r   <= resp_r.kind;
        value_r  <= '0;
        status_r <= resp_r.status;
        last_r   <= 1'b1;
      end
    end
  end

  assign out_ch.valid  = out_vld_r;
  assign out_ch.kind   = kind_r;
  assign out_ch.value  = value_r;
  assign out_ch.status = status_r;
  assign out_ch.length = length_r;
  assign out_ch.last   = last_r;

  // Checks
  `SBE_ASSERT_ALWAYS(a_fill_max, fill_r <= CAP_C, "fill count above capacity")
  `SBE_ASSERT_IMPL(a_keep_le_read, state_r == S_RMV, k_r <= i_r, "kept more than read")
  `SBE_ASSERT_IMPL(a_read_bound, state_r == S_READ, rem_r <= fill_r, "read-out beyond length")
  `SBE_ASSERT_IMPL(a_elem_beat, out_vld_r && (kind_r == KIND_ELEM), !last_r && (status_r == ST_OK), "element beat flagged last or bad status")
  `SBE_ASSERT_NEXT(a_leave_idle, in_fire, state_r != S_IDLE, "request accepted without work")

endmodule

@@ src/sbe_store.sv @@
// Circular entry store: one write port, one read port with registered data.
// Depends on sbe_pkg for the word width.
module sbe_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [AW-1:0]                    wr_addr,
  input  logic signed [sbe_pkg::DATA_W-1:0] wr_data,
  input  logic                             rd_en,
  input  logic [AW-1:0]                    rd_addr,
  output logic signed [sbe_pkg::DATA_W-1:0] rd_data
);
  import sbe_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold the read word until the next read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

@@ src/sbe_alu.sv @@
// Shared slot arithmetic and compare unit: wrap-around add, write-pointer
// advance and word compare. Depends on sbe_pkg for the word width.
module sbe_alu #(
  parameter int CAPACITY = 32,
  parameter int IW       = 5
) (
  input  logic [IW-1:0]                     base,
  input  logic [IW-1:0]                     offset,
  input  logic [IW-1:0]                     wr_slot,
  input  logic signed [sbe_pkg::DATA_W-1:0] cmp_a,
  input  logic signed [sbe_pkg::DATA_W-1:0] cmp_b,
  output logic [IW-1:0]                     slot,
  output logic [IW-1:0]                     wr_next,
  output logic                              neq
);
  import sbe_pkg::*;

  localparam logic [IW:0]   CAP_X  = (IW+1)'(CAPACITY);
  localparam logic [IW-1:0] LAST_S = IW'(CAPACITY - 1);

  logic [IW:0] sum;

  // Both operands stay below the capacity, so one subtract wraps the sum.
  always_comb begin
    sum = {1'b0, base} + {1'b0, offset};
    if (sum >= CAP_X) begin
      sum = sum - CAP_X;
    end
    slot = sum[IW-1:0];
  end

  assign wr_next = (wr_slot == LAST_S) ? '0 : wr_slot + IW'(1);
  assign neq     = (cmp_a != cmp_b);
endmodule

@@ test/sequence_buffer_engine_test.sv @@
// Self-checking testbench for sequence_buffer_engine: a directed table, then random request
// episodes, each result beat checked against its typed row or a built-in deque predictor.
// Depends on sbe_pkg, sbe_in_if/sbe_out_if (sbe_if.sv) and the engine RTL.
module sequence_buffer_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sbe_pkg::*;

  localparam int DEPTH       = 32;
  localparam int TOTAL_ITEMS = 430;
  localparam int PLAN_LEN    = 25;
  localparam int TAIL_CYCLES = 40;

  localparam logic signed [DATA_W-1:0] MIN_WORD = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] MAX_WORD = 32'sh7FFF_FFFF;

  // One result beat as the engine should present it.
  typedef struct {
    kind_t                    kind;
    logic signed [DATA_W-1:0] value;
    status_t                  status;
    logic [LEN_W-1:0]         length;
    logic                     last;
  } beat_t;

  // One row of the directed table. Where typed is set, the single result beat is
  // written out in the row (value zero, last set); otherwise the predictor supplies it.
  typedef struct {
    req_t                     req;
    logic signed [DATA_W-1:0] opnd;
    bit                       typed;
    kind_t                    kind;
    status_t                  status;
    logic [LEN_W-1:0]         length;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sbe_in_if  in_ch ();
  sbe_out_if out_ch ();

  sequence_buffer_engine #(
    .CAPACITY(DEPTH)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: a circular store with a front position and a fill count.
  logic signed [DATA_W-1:0] store_q [DEPTH];
  int    head = 0;
  int    fill = 0;

  beat_t step_beats[$];     // beats caused by the request just accepted
  beat_t pending_beats[$];  // beats still owed by the engine, oldest first

  int    fail_count = 0;
  int    beat_count = 0;
  int    sent = 0;
  bit    gaps_on = 1'b1;

  row_t plan [PLAN_LEN] = '{
    // Empty store straight after reset: every removal flags empty, bad counts flag.
    '{REQ_RMV_FRONT,  32'sd0,          1'b1, KIND_ACK, ST_EMPTY, 6'd0},
    '{REQ_RMV_BACK,   32'sd0,          1'b1, KIND_ACK, ST_EMPTY, 6'd0},
    '{REQ_RMV_VALUE,  32'sd0,          1'b1, KIND_ACK, ST_EMPTY, 6'd0},
    '{REQ_READ_FIRST, 32'sd0,          1'b1, KIND_END, ST_COUNT, 6'd0},
    '{REQ_READ_LAST,  32'sh8000_0000,  1'b1, KIND_END, ST_COUNT, 6'd0},
    '{REQ_READ_FIRST, 32'sd5,          1'b1, KIND_END, ST_OK,    6'd0},
    // Build -1, MIN, MAX, 0, MIN, MIN from both ends.
    '{REQ_ADD_BACK,   32'sh7FFF_FFFF,  1'b1, KIND_ACK, ST_OK,    6'd1},
    '{REQ_ADD_FRONT,  32'sh8000_0000,  1'b1, KIND_ACK, ST_OK,    6'd2},
    '{REQ_ADD_BACK,   32'sd0,          1'b1, KIND_ACK, ST_OK,    6'd3},
    '{REQ_ADD_FRONT,  32'shFFFF_FFFF,  1'b1, KIND_ACK, ST_OK,    6'd4},
    '{REQ_ADD_BACK,   32'sh8000_0000,  1'b1, KIND_ACK, ST_OK,    6'd5},
    '{REQ_ADD_BACK,   32'sh8000_0000,  1'b1, KIND_ACK, ST_OK,    6'd6},
    // Count far above the length reads everything; then a short tail read.
    '{REQ_READ_FIRST, 32'sh7FFF_FFFF,  1'b0, KIND_ACK, ST_OK,    6'd0},
    '{REQ_READ_LAST,  32'sd2,          1'b0, KIND_ACK, ST_OK,    6'd0},
    // Remove scattered and adjacent copies, then a value that is not there.
    '{REQ_RMV_VALUE,  32'sh8000_0000,  1'b0, KIND_ACK, ST_OK,    6'd0},
    '{REQ_RMV_VALUE,  32'sd12345,      1'b0, KIND_ACK, ST_OK,    6'd0},
    '{REQ_READ_LAST,  32'shFFFF_FFFF,  1'b1, KIND_END, ST_COUNT, 6'd3},
    '{REQ_RMV_FRONT,  32'sd0,          1'b0, KIND_ACK, ST_OK,    6'd0},
    '{REQ_RMV_BACK,   32'sd0,          1'b0, KIND_ACK, ST_OK,    6'd0},
    '{REQ_READ_LAST,  32'sd10,         1'b0, KIND_ACK, ST_OK,    6'd0},
    // Removing the only remaining entry by value empties the store.
    '{REQ_RMV_VALUE,  32'sh7FFF_FFFF,  1'b0, KIND_ACK, ST_OK,    6'd0},
    '{REQ_ADD_FRONT,  32'sh5555_AAAA,  1'b1, KIND_ACK, ST_OK,    6'd1},
    '{REQ_CLEAR,      32'sd0,          1'b1, KIND_ACK, ST_OK,    6'd0},
    '{REQ_CLEAR,      32'shFFFF_FFFF,  1'b1, KIND_ACK, ST_OK,    6'd0},
    '{REQ_ADD_BACK,   32'shAAAA_5555,  1'b1, KIND_ACK, ST_OK,    6'd1}
  };

  function automatic void add_beat(kind_t k, logic signed [DATA_W-1:0] v, status_t s, bit lst);
    beat_t b;
    b.kind   = k;
    b.value  = v;
    b.status = s;
    b.length = LEN_W'(fill);
    b.last   = lst;
    step_beats.push_back(b);
  endfunction

  // Advance the deque by one accepted request and collect the beats it owes.
  function automatic void predict_request(req_t req, logic signed [DATA_W-1:0] opnd);
    status_t st;
    int      keep;
    int      n;
    int      first;
    logic signed [DATA_W-1:0] v;
    st = ST_OK;
    step_beats.delete();
    case (req)
      REQ_ADD_FRONT: begin
        if (fill >= DEPTH) begin
          st = ST_FULL;
        end else begin
          head = (head + DEPTH - 1) % DEPTH;
          store_q[head] = opnd;
          fill++;
        end
      end
      REQ_ADD_BACK: begin
        if (fill >= DEPTH) begin
          st = ST_FULL;
        end else begin
          store_q[(head + fill) % DEPTH] = opnd;
          fill++;
        end
      end
      REQ_RMV_FRONT: begin
        if (fill == 0) begin
          st = ST_EMPTY;
        end else begin
          head = (head + 1) % DEPTH;
          fill--;
        end
      end
      REQ_RMV_BACK: begin
        if (fill == 0) st = ST_EMPTY;
        else fill--;
      end
      REQ_RMV_VALUE: begin
        if (fill == 0) begin
          st = ST_EMPTY;
        end else begin
          // Compact survivors towards the front, keeping their order.
          keep = 0;
          for (int i = 0; i < fill; i++) begin
            v = store_q[(head + i) % DEPTH];
            if (v !== opnd) begin
              store_q[(head + keep) % DEPTH] = v;
              keep++;
            end
          end
          fill = keep;
        end
      end
      REQ_READ_FIRST, REQ_READ_LAST: begin
        if (opnd <= 0) begin
          add_beat(KIND_END, '0, ST_COUNT, 1'b1);
          return;
        end
        n = (opnd < fill) ? int'(opnd) : fill;
        first = (req == REQ_READ_FIRST) ? 0 : fill - n;
        for (int i = 0; i < n; i++)
          add_beat(KIND_ELEM, store_q[(head + first + i) % DEPTH], ST_OK, 1'b0);
        add_beat(KIND_END, '0, ST_OK, 1'b1);
        return;
      end
      default: begin
        head = 0;
        fill = 0;
      end
    endcase
    add_beat(KIND_ACK, '0, st, 1'b1);
  endfunction

  // Present one request, hold it until the engine takes the beat, then queue what it owes.
  task automatic send_request(req_t req, logic signed [DATA_W-1:0] opnd, bit typed = 1'b0,
                              kind_t tk = KIND_ACK, status_t ts = ST_OK,
                              logic [LEN_W-1:0] tl = '0);
    beat_t b;
    // Idle in bursts, with calm stretches, and none at all near the end.
    gaps_on = (sent < TOTAL_ITEMS - 50) && ((sent / 40) % 4 != 3);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= req;
    in_ch.operand  <= opnd;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    predict_request(req, opnd);
    if (typed) begin
      b.kind   = tk;
      b.value  = '0;
      b.status = ts;
      b.length = tl;
      b.last   = 1'b1;
      pending_beats.push_back(b);
    end else begin
      foreach (step_beats[i]) pending_beats.push_back(step_beats[i]);
    end
  endtask

  // Favour a small pool so that duplicates and value matches are common.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sd0;
      1: return -32'sd1;
      2: return MIN_WORD;
      3: return MAX_WORD;
      4: return 32'sd1;
      5: return 32'sd42;
      default: return $urandom();
    endcase
  endfunction

  // Read counts around the current length, plus zero, negatives and huge values.
  function automatic logic signed [DATA_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0: return 32'sd0;
      1: return {1'b1, 31'($urandom())};
      2: return 32'sd1;
      3: return DATA_W'(fill);
      4: return DATA_W'(fill + 1);
      5: return MAX_WORD;
      6: return $urandom();
      default: return DATA_W'($urandom_range(1, DEPTH + 2));
    endcase
  endfunction

  function automatic void note_mismatch(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%t: %s", $realtime, msg);
  endfunction

  // Check every result beat against the oldest expectation, field by field.
  always @(posedge clk) begin : watch_results
    beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      beat_count++;
      if (pending_beats.size() == 0) begin
        note_mismatch($sformatf("beat %0d with nothing expected: kind %0d value %0d status %0d",
                                beat_count, out_ch.kind, out_ch.value, out_ch.status));
      end else begin
        want = pending_beats.pop_front();
        if (out_ch.kind !== want.kind || out_ch.value !== want.value ||
            out_ch.status !== want.status || out_ch.length !== want.length ||
            out_ch.last !== want.last)
          note_mismatch($sformatf({"beat %0d: expected kind %0d value %0d status %0d ",
                                   "length %0d last %0d, got %0d %0d %0d %0d %0d"},
                                  beat_count, want.kind, want.value, want.status,
                                  want.length, want.last, out_ch.kind, out_ch.value,
                                  out_ch.status, out_ch.length, out_ch.last));
      end
    end
  end

  // Result side: stall in bursts while gaps are on, otherwise stay ready.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Stimulus: reset, directed table, random episodes, then drain and report.
  initial begin
    int n;
    logic signed [DATA_W-1:0] v;
    in_ch.valid    <= 1'b0;
    in_ch.req_type <= REQ_CLEAR;
    in_ch.operand  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i])
      send_request(plan[i].req, plan[i].opnd, plan[i].typed, plan[i].kind,
                   plan[i].status, plan[i].length);

    while (sent < TOTAL_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          // Fill to capacity from either end, then knock on the full store.
          n = DEPTH - fill + $urandom_range(1, 3);
          repeat (n)
            send_request($urandom_range(0, 1) ? REQ_ADD_FRONT : REQ_ADD_BACK, pick_value());
        end
        2: begin
          // Drain past empty.
          n = fill + $urandom_range(1, 2);
          repeat (n)
            send_request($urandom_range(0, 1) ? REQ_RMV_FRONT : REQ_RMV_BACK, pick_value());
        end
        3, 4, 5: begin
          send_request($urandom_range(0, 1) ? REQ_READ_FIRST : REQ_READ_LAST, pick_count());
        end
        6, 7: begin
          // Mostly remove a value that is actually stored.
          if (fill != 0 && $urandom_range(0, 3) != 0)
            v = store_q[(head + $urandom_range(0, fill - 1)) % DEPTH];
          else
            v = pick_value();
          send_request(REQ_RMV_VALUE, v);
        end
        default: begin
          // Noise: any request code, any operand.
          repeat ($urandom_range(1, 6))
            send_request(req_t'($urandom_range(0, 7)), $urandom());
        end
      endcase
    end

    gaps_on = 1'b0;
    in_ch.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    // Leave room for any stray beat to show up.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ sequence_buffer_engine.f @@
+incdir+src
src/sbe_pkg.sv
src/sbe_if.sv
src/sbe_store.sv
src/sbe_alu.sv
src/sequence_buffer_engine.sv
test/sequence_buffer_engine_test.sv
